/* hdl/sprg_pkg.sv */
// Shared types and constants for the stepper pulse ramp generator.
// Used by the channel interfaces and the top level; no dependencies.

package sprg_pkg;

    // Payload widths
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned NOW_W    = 32;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned STEPS_W  = 17;

    // Configuration port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned REG_IDX_W  = 3;

    // Item actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_START     = 2'd0,
        ACT_DEST_TICK = 2'd1,
        ACT_FREE_TICK = 2'd2
    } t_action;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [REG_IDX_W-1:0] {
        REG_STEP_COUNT      = 3'd0,
        REG_REQUESTED_DELAY = 3'd1,
        REG_MIN_DELAY       = 3'd2,
        REG_MOVE_DIRECTION  = 3'd3,
        REG_MICROSTEP_LOG2  = 3'd4,
        REG_ENABLE_LEVEL    = 3'd5
    } t_reg_idx;

    // Delay constants in ms, plus the ramp margin and the largest microstep mode
    localparam logic [DELAY_W-1:0] START_DELAY_MS = 16'd3000;
    localparam logic [DELAY_W-1:0] RESET_DELAY_MS = 16'd2000;
    localparam logic [DELAY_W-1:0] RESET_TARGET_MS = 16'd800;
    localparam logic [DELAY_W-1:0] RAMP_DEST_MS   = 16'd100;
    localparam logic [DELAY_W-1:0] RAMP_FREE_MS   = 16'd50;
    localparam logic [DELAY_W:0]   RAMP_MARGIN    = 17'd2;
    localparam logic [MODE_W-1:0]  MODE_MAX       = 3'd5;

    // Configuration register reset values
    localparam logic [DELAY_W-1:0] RST_REQ_DELAY = 16'd800;
    localparam logic [DELAY_W-1:0] RST_MIN_DELAY = 16'd1;

endpackage

/* hdl/sprg_if.sv */
// Valid/ready channel interfaces for the stepper pulse ramp generator.
// Depends on sprg_pkg for the payload widths.

interface sprg_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [sprg_pkg::ACTION_W-1:0]     action;
    logic [sprg_pkg::NOW_W-1:0]        now_ms;
    logic [sprg_pkg::DELAY_W-1:0]      free_delay;
    logic                              free_direction;

    modport source (output valid, action, now_ms, free_delay, free_direction,
                    input ready);
    modport sink   (input valid, action, now_ms, free_delay, free_direction,
                    output ready);
endinterface

interface sprg_res_if;
    logic                              valid;
    logic                              ready;
    logic                              step_level;
    logic                              dir_level;
    logic [sprg_pkg::MODE_W-1:0]       mode_pins;
    logic                              enable_pin;
    logic [sprg_pkg::STEPS_W-1:0]      steps_left;
    logic [sprg_pkg::DELAY_W-1:0]      step_delay;

    modport source (output valid, step_level, dir_level, mode_pins, enable_pin,
                    steps_left, step_delay, input ready);
    modport sink   (input valid, step_level, dir_level, mode_pins, enable_pin,
                    steps_left, step_delay, output ready);
endinterface

/* hdl/stepper_pulse_ramp_generator_unit.sv */
// Top level of the stepper pulse ramp generator: APB registers, ramp and
// toggle logic, result register. Depends on sprg_pkg and sprg_if.sv.
//
// Each command transaction (start, destination tick or free-move tick) is
// computed combinationally: the ramp compare, the toggle-due compare and the
// state update sit between the command port and the result register, so a
// new command is taken every cycle while the result side keeps up, and one
// stalled result is held in the result register. The result shows the STEP,
// DIR, mode and enable pin levels, remaining half-period toggles and the
// working delay after that command. Time stamps wrap modulo 2^TIME_BITS.
// Configuration registers sit at byte address 4*index and must only be
// written while no command is in flight.

module stepper_pulse_ramp_generator_unit #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sprg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sprg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sprg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // Channels
    sprg_cmd_if.sink                           i_cmd,
    sprg_res_if.source                         o_res
);

    localparam int unsigned DW = sprg_pkg::DELAY_W;

    // Configuration registers
    logic [sprg_pkg::COUNT_W-1:0] r_step_count;
    logic [DW-1:0]                r_req_delay;
    logic [DW-1:0]                r_min_delay;
    logic                         r_move_dir;
    logic [sprg_pkg::MODE_W-1:0]  r_ustep_log2;
    logic                         r_enable_level;

    // Motion state
    logic [DW-1:0]                r_work_delay,   n_work_delay;
    logic [DW-1:0]                r_target_delay, n_target_delay;
    logic [sprg_pkg::STEPS_W-1:0] r_remaining,    n_remaining;
    logic [TIME_BITS-1:0]         r_last_toggle,  n_last_toggle;
    logic [TIME_BITS-1:0]         r_last_ramp,    n_last_ramp;
    logic                         r_step_pin,     n_step_pin;
    logic                         r_dir_pin,      n_dir_pin;
    logic [sprg_pkg::MODE_W-1:0]  r_mode,         n_mode;

    // Result register
    logic                         r_res_valid;
    logic                         r_res_enable;

    logic                         cmd_accept;
    logic                         cfg_write;
    logic [sprg_pkg::REG_IDX_W-1:0] cfg_idx;
    logic [TIME_BITS-1:0]         now_t;
    logic [DW-1:0]                tick_target;
    logic [DW-1:0]                tick_period;
    logic                         ramp_on;
    logic [DW-1:0]                ramped_delay;
    logic                         toggle_due;
    logic [TIME_BITS-1:0]         ramp_elapsed;
    logic [TIME_BITS-1:0]         toggle_elapsed;

    // Handshake: result register frees up when taken
    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;

    // APB decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[sprg_pkg::APB_ADDR_W-1:2];

    always_comb begin
        unique case (cfg_idx)
            sprg_pkg::REG_STEP_COUNT:
                prdata = sprg_pkg::APB_DATA_W'(r_step_count);
            sprg_pkg::REG_REQUESTED_DELAY:
                prdata = sprg_pkg::APB_DATA_W'(r_req_delay);
            sprg_pkg::REG_MIN_DELAY:
                prdata = sprg_pkg::APB_DATA_W'(r_min_delay);
            sprg_pkg::REG_MOVE_DIRECTION:
                prdata = sprg_pkg::APB_DATA_W'(r_move_dir);
            sprg_pkg::REG_MICROSTEP_LOG2:
                prdata = sprg_pkg::APB_DATA_W'(r_ustep_log2);
            sprg_pkg::REG_ENABLE_LEVEL:
                prdata = sprg_pkg::APB_DATA_W'(r_enable_level);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count   <= '0;
            r_req_delay    <= sprg_pkg::RST_REQ_DELAY;
            r_min_delay    <= sprg_pkg::RST_MIN_DELAY;
            r_move_dir     <= 1'b0;
            r_ustep_log2   <= '0;
            r_enable_level <= 1'b1;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                sprg_pkg::REG_STEP_COUNT:      r_step_count   <= pwdata[sprg_pkg::COUNT_W-1:0];
                sprg_pkg::REG_REQUESTED_DELAY: r_req_delay    <= pwdata[DW-1:0];
                sprg_pkg::REG_MIN_DELAY:       r_min_delay    <= pwdata[DW-1:0];
                sprg_pkg::REG_MOVE_DIRECTION:  r_move_dir     <= pwdata[0];
                sprg_pkg::REG_MICROSTEP_LOG2:  r_ustep_log2   <= pwdata[sprg_pkg::MODE_W-1:0];
                sprg_pkg::REG_ENABLE_LEVEL:    r_enable_level <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Time stamp at the block's time width
    assign now_t = TIME_BITS'({32'd0, i_cmd.now_ms});

    // Ramp toward the target of the current tick kind
    assign tick_target = (i_cmd.action == sprg_pkg::ACT_DEST_TICK) ? r_target_delay
                                                                   : i_cmd.free_delay;
    assign tick_period = (i_cmd.action == sprg_pkg::ACT_DEST_TICK) ? sprg_pkg::RAMP_DEST_MS
                                                                   : sprg_pkg::RAMP_FREE_MS;
    assign ramp_on        = {1'b0, r_work_delay} > ({1'b0, tick_target} + sprg_pkg::RAMP_MARGIN);
    assign ramp_elapsed   = now_t - r_last_ramp;
    assign toggle_elapsed = now_t - r_last_toggle;

    always_comb begin
        if (!ramp_on)
            ramped_delay = tick_target;
        else if (ramp_elapsed >= TIME_BITS'(tick_period))
            ramped_delay = r_work_delay - 16'd1;
        else
            ramped_delay = r_work_delay;
    end

    assign toggle_due = toggle_elapsed >= TIME_BITS'(ramped_delay);

    // Next motion state for an accepted command
    always_comb begin
        n_work_delay   = r_work_delay;
        n_target_delay = r_target_delay;
        n_remaining    = r_remaining;
        n_last_toggle  = r_last_toggle;
        n_last_ramp    = r_last_ramp;
        n_step_pin     = r_step_pin;
        n_dir_pin      = r_dir_pin;
        n_mode         = r_mode;
        unique case (i_cmd.action) inside
            sprg_pkg::ACT_START: begin
                n_remaining    = {r_step_count, 1'b0};
                n_dir_pin      = r_move_dir;
                if (r_ustep_log2 <= sprg_pkg::MODE_MAX)
                    n_mode = r_ustep_log2;
                n_target_delay = (r_req_delay < r_min_delay) ? r_min_delay : r_req_delay;
                n_work_delay   = sprg_pkg::START_DELAY_MS;
            end
            sprg_pkg::ACT_DEST_TICK, sprg_pkg::ACT_FREE_TICK: begin
                n_work_delay = ramped_delay;
                if (ramp_on && (ramp_elapsed >= TIME_BITS'(tick_period)))
                    n_last_ramp = now_t;
                if (i_cmd.action == sprg_pkg::ACT_DEST_TICK) begin
                    if (toggle_due && (r_remaining != '0)) begin
                        n_step_pin    = !r_step_pin;
                        n_remaining   = r_remaining - 17'd1;
                        n_last_toggle = now_t;
                    end
                end else if (toggle_due) begin
                    n_step_pin    = !r_step_pin;
                    n_last_toggle = now_t;
                    n_dir_pin     = i_cmd.free_direction;
                end
            end
            default: ;
        endcase
    end

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_delay   <= sprg_pkg::RESET_DELAY_MS;
            r_target_delay <= sprg_pkg::RESET_TARGET_MS;
            r_remaining    <= '0;
            r_last_toggle  <= '0;
            r_last_ramp    <= '0;
            r_step_pin     <= 1'b0;
            r_dir_pin      <= 1'b0;
            r_mode         <= '0;
            r_res_valid    <= 1'b0;
        end else begin
            if (cmd_accept) begin
                r_work_delay   <= n_work_delay;
                r_target_delay <= n_target_delay;
                r_remaining    <= n_remaining;
                r_last_toggle  <= n_last_toggle;
                r_last_ramp    <= n_last_ramp;
                r_step_pin     <= n_step_pin;
                r_dir_pin      <= n_dir_pin;
                r_mode         <= n_mode;
                r_res_valid    <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid    <= 1'b0;
            end
        end
    end

    // Enable level captured with the transaction
    always_ff @(posedge i_clk) begin
        if (cmd_accept)
            r_res_enable <= r_enable_level;
    end

    assign o_res.valid      = r_res_valid;
    assign o_res.step_level = r_step_pin;
    assign o_res.dir_level  = r_dir_pin;
    assign o_res.mode_pins  = r_mode;
    assign o_res.enable_pin = r_res_enable;
    assign o_res.steps_left = r_remaining;
    assign o_res.step_delay = r_work_delay;

endmodule
